// ===== design/first_fit_heap_allocator_assert.svh =====
// Assertion macros shared by the allocator modules.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FFHA_ASSERT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed in %m");

// Next-cycle implication, disabled during reset.
`define FFHA_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed in %m");

`endif

// ===== design/ffha_pkg.sv =====
// Package with the types and constants of the first-fit heap allocator.
package ffha_pkg;

   localparam int ARENA_BYTES_DEF = 4096;
   localparam int HDR_BYTES       = 4;
   localparam int FLAG_NUM        = 2;
   localparam int FLAG_FREE       = 0;
   localparam int FLAG_LAST       = 1;

   localparam int OP_W        = 2;
   localparam int SIZE_W      = 13;
   localparam int OFFS_W      = 12;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 16;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_FORMAT  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC_WALK,
      ST_ALLOC_SPLIT,
      ST_REL_WALK,
      ST_MERGE_START,
      ST_MERGE_HDR,
      ST_MERGE_NXT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic              status;
      logic [OFFS_W-1:0] granted_offset;
   } result_type;

endpackage

// ===== design/ffha_hdr_mem.sv =====
// Header store: one synchronous memory, one read and one write port, entry 0 reset mark.
module ffha_hdr_mem #(
   parameter int ARENA_BYTES = ffha_pkg::ARENA_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rd_en,
   input  logic [$clog2(ARENA_BYTES)-1:0]       rd_addr,
   output logic [$clog2(ARENA_BYTES+1)+ffha_pkg::FLAG_NUM-1:0] rd_data,
   input  logic                                 wr_en,
   input  logic [$clog2(ARENA_BYTES)-1:0]       wr_addr,
   input  logic [$clog2(ARENA_BYTES+1)+ffha_pkg::FLAG_NUM-1:0] wr_data
);

   localparam int AW = $clog2(ARENA_BYTES);
   localparam int SW = $clog2(ARENA_BYTES + 1);
   localparam int HW = SW + ffha_pkg::FLAG_NUM;

   logic [HW-1:0] store_ff [ARENA_BYTES];
   logic [HW-1:0] rd_q_ff;
   logic          rd_dflt_ff;
   logic          hdr0_valid_ff;
   logic [HW-1:0] reset_hdr;

   always_comb begin
      reset_hdr                      = '0;
      reset_hdr[HW-1:ffha_pkg::FLAG_NUM] = SW'(ARENA_BYTES);
      reset_hdr[ffha_pkg::FLAG_FREE] = 1'b1;
      reset_hdr[ffha_pkg::FLAG_LAST] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr0_valid_ff <= 1'b0;
         rd_dflt_ff    <= 1'b0;
      end else begin
         if (wr_en && (wr_addr == AW'(0))) begin
            hdr0_valid_ff <= 1'b1;
         end
         if (rd_en) begin
            rd_dflt_ff <= (rd_addr == AW'(0)) && !hdr0_valid_ff;
         end
      end
   end

   assign rd_data = rd_dflt_ff ? reset_hdr : rd_q_ff;

endmodule

// ===== design/ffha_ctrl.sv =====
// Sequencer that formats, walks, splits, frees and merges block headers in the header store.
module ffha_ctrl #(
   parameter int ARENA_BYTES = ffha_pkg::ARENA_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ffha_pkg::OP_W-1:0]            req_operation,
   input  logic [ffha_pkg::SIZE_W-1:0]          req_size_bytes,
   input  logic [ffha_pkg::OFFS_W-1:0]          req_payload_offset,
   output logic                                 res_valid,
   input  logic                                 res_ready,
   output ffha_pkg::result_type                 res,
   output logic                                 rd_en,
   output logic [$clog2(ARENA_BYTES)-1:0]       rd_addr,
   input  logic [$clog2(ARENA_BYTES+1)+ffha_pkg::FLAG_NUM-1:0] rd_data,
   output logic                                 wr_en,
   output logic [$clog2(ARENA_BYTES)-1:0]       wr_addr,
   output logic [$clog2(ARENA_BYTES+1)+ffha_pkg::FLAG_NUM-1:0] wr_data
);

   `include "first_fit_heap_allocator_assert.svh"

   localparam int AW = $clog2(ARENA_BYTES);
   localparam int SW = $clog2(ARENA_BYTES + 1);
   localparam int HW = SW + ffha_pkg::FLAG_NUM;
   localparam int XW = SW + 2;

   ffha_pkg::state_type  state_ff, state_in;
   logic [AW-1:0]        cur_ff, cur_in;
   logic [HW-1:0]        hdr_ff, hdr_in;
   logic [XW-1:0]        total_ff, total_in;
   logic [ffha_pkg::OFFS_W-1:0] payload_ff, payload_in;
   ffha_pkg::result_type res_ff, res_in;

   logic [31:0]   sat32;
   logic [SW-1:0] sat;
   logic [SW-1:0] rd_size;
   logic [AW-1:0] rd_next;
   logic [HW-1:0] merged;
   logic [AW-1:0] naddr;

   function automatic logic [SW-1:0] f_size(input logic [HW-1:0] h);
      return h[HW-1:ffha_pkg::FLAG_NUM];
   endfunction

   function automatic logic [HW-1:0] f_make(input logic [SW-1:0] sz, input logic fr,
                                            input logic la);
      logic [HW-1:0] h;
      h                          = '0;
      h[HW-1:ffha_pkg::FLAG_NUM] = sz;
      h[ffha_pkg::FLAG_FREE]     = fr;
      h[ffha_pkg::FLAG_LAST]     = la;
      return h;
   endfunction

   function automatic logic f_has_next(input logic [AW-1:0] off, input logic [HW-1:0] h);
      logic [XW-1:0] endp;
      endp = XW'(off) + XW'(f_size(h));
      return !h[ffha_pkg::FLAG_LAST] && (f_size(h) != '0) && (endp < XW'(ARENA_BYTES));
   endfunction

   function automatic logic [AW-1:0] f_next(input logic [AW-1:0] off, input logic [HW-1:0] h);
      return AW'(XW'(off) + XW'(f_size(h)));
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffha_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      hdr_ff     <= hdr_in;
      total_ff   <= total_in;
      payload_ff <= payload_in;
      res_ff     <= res_in;
   end

   always_comb begin
      sat32 = (32'(req_size_bytes) > 32'(ARENA_BYTES)) ? 32'(ARENA_BYTES)
                                                         : 32'(req_size_bytes);
      sat     = SW'(sat32);
      rd_size = f_size(rd_data);
      rd_next = f_next(cur_ff, rd_data);
      merged  = f_make(SW'(XW'(f_size(hdr_ff)) + XW'(rd_size)), 1'b1,
                       rd_data[ffha_pkg::FLAG_LAST]);
      naddr   = f_next(cur_ff, hdr_ff);
   end

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      hdr_in     = hdr_ff;
      total_in   = total_ff;
      payload_in = payload_ff;
      res_in     = res_ff;
      req_ready  = 1'b0;
      res_valid  = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = cur_ff;
      wr_en      = 1'b0;
      wr_addr    = cur_ff;
      wr_data    = hdr_ff;

      unique case (state_ff)
         ffha_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               total_in   = XW'(sat) + XW'(ffha_pkg::HDR_BYTES);
               payload_in = req_payload_offset;
               cur_in     = '0;
               res_in     = '{status: ffha_pkg::STATUS_FAIL, granted_offset: '0};
               state_in   = ffha_pkg::ST_RESP;
               unique case (ffha_pkg::op_type'(req_operation))
                  ffha_pkg::OP_ALLOC: begin
                     if (sat != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = ffha_pkg::ST_ALLOC_WALK;
                     end
                  end
                  ffha_pkg::OP_RELEASE: begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = ffha_pkg::ST_REL_WALK;
                  end
                  ffha_pkg::OP_FORMAT: begin
                     if (sat >= SW'(ffha_pkg::HDR_BYTES)) begin
                        wr_en          = 1'b1;
                        wr_addr        = '0;
                        wr_data        = f_make(sat, 1'b1, 1'b1);
                        res_in.status  = ffha_pkg::STATUS_OK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ffha_pkg::ST_ALLOC_WALK: begin
            if (rd_data[ffha_pkg::FLAG_FREE] && (XW'(rd_size) >= total_ff)) begin
               res_in.status         = ffha_pkg::STATUS_OK;
               res_in.granted_offset = ffha_pkg::OFFS_W'(32'(cur_ff) + 32'(ffha_pkg::HDR_BYTES));
               wr_en                 = 1'b1;
               wr_addr               = cur_ff;
               if ((XW'(rd_size) - total_ff < XW'(ffha_pkg::HDR_BYTES)) ||
                   (XW'(cur_ff) + total_ff >= XW'(ARENA_BYTES))) begin
                  wr_data  = f_make(rd_size, 1'b0, rd_data[ffha_pkg::FLAG_LAST]);
                  state_in = ffha_pkg::ST_RESP;
               end else begin
                  wr_data  = f_make(SW'(total_ff), 1'b0, 1'b0);
                  cur_in   = AW'(XW'(cur_ff) + total_ff);
                  hdr_in   = f_make(SW'(XW'(rd_size) - total_ff), 1'b1,
                                    rd_data[ffha_pkg::FLAG_LAST]);
                  state_in = ffha_pkg::ST_ALLOC_SPLIT;
               end
            end else if (f_has_next(cur_ff, rd_data)) begin
               cur_in  = rd_next;
               rd_en   = 1'b1;
               rd_addr = rd_next;
            end else begin
               state_in = ffha_pkg::ST_RESP;
            end
         end

         ffha_pkg::ST_ALLOC_SPLIT: begin
            wr_en    = 1'b1;
            wr_addr  = cur_ff;
            wr_data  = hdr_ff;
            state_in = ffha_pkg::ST_RESP;
         end

         ffha_pkg::ST_REL_WALK: begin
            if (!rd_data[ffha_pkg::FLAG_FREE] &&
                (32'(cur_ff) + 32'(ffha_pkg::HDR_BYTES) == 32'(payload_ff))) begin
               wr_en         = 1'b1;
               wr_addr       = cur_ff;
               wr_data       = rd_data | (HW'(1) << ffha_pkg::FLAG_FREE);
               res_in.status = ffha_pkg::STATUS_OK;
               state_in      = ffha_pkg::ST_MERGE_START;
            end else if (f_has_next(cur_ff, rd_data)) begin
               cur_in  = rd_next;
               rd_en   = 1'b1;
               rd_addr = rd_next;
            end else begin
               state_in = ffha_pkg::ST_RESP;
            end
         end

         ffha_pkg::ST_MERGE_START: begin
            cur_in   = '0;
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = ffha_pkg::ST_MERGE_HDR;
         end

         ffha_pkg::ST_MERGE_HDR: begin
            hdr_in = rd_data;
            if (!f_has_next(cur_ff, rd_data)) begin
               state_in = ffha_pkg::ST_RESP;
            end else if (rd_data[ffha_pkg::FLAG_FREE]) begin
               rd_en    = 1'b1;
               rd_addr  = rd_next;
               state_in = ffha_pkg::ST_MERGE_NXT;
            end else begin
               cur_in  = rd_next;
               rd_en   = 1'b1;
               rd_addr = rd_next;
            end
         end

         ffha_pkg::ST_MERGE_NXT: begin
            if (rd_data[ffha_pkg::FLAG_FREE]) begin
               wr_en   = 1'b1;
               wr_addr = cur_ff;
               wr_data = merged;
               hdr_in  = merged;
               if (f_has_next(cur_ff, merged)) begin
                  rd_en   = 1'b1;
                  rd_addr = f_next(cur_ff, merged);
               end else begin
                  state_in = ffha_pkg::ST_RESP;
               end
            end else begin
               cur_in = naddr;
               hdr_in = rd_data;
               if (f_has_next(naddr, rd_data)) begin
                  cur_in   = f_next(naddr, rd_data);
                  rd_en    = 1'b1;
                  rd_addr  = f_next(naddr, rd_data);
                  state_in = ffha_pkg::ST_MERGE_HDR;
               end else begin
                  state_in = ffha_pkg::ST_RESP;
               end
            end
         end

         ffha_pkg::ST_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ffha_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ffha_pkg::ST_IDLE;
         end
      endcase
   end

   assign res = res_ff;

   `FFHA_ASSERT(a_no_rw_collide, clock, reset, rd_en && wr_en, rd_addr != wr_addr)
   `FFHA_ASSERT_NEXT(a_res_held, clock, reset, res_valid && !res_ready, res_valid)
   `FFHA_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready,
                     state_ff != ffha_pkg::ST_IDLE)

endmodule

// ===== design/first_fit_heap_allocator.sv =====
// Format, zero-size allocate and unused codes go straight to the response; allocate walks
// the headers and, on a split, writes a second header; release walks the headers and, on a
// hit, runs a merge pass from entry 0 that joins adjacent free blocks. One request is in
// flight at a time; the single header memory read port, one header per cycle, sets the rate.
// Reset is synchronous; entry 0 then reads as one free last block of the whole arena and
// no clearing pass runs, so the next request is accepted in the cycle after reset.
module first_fit_heap_allocator #(
   parameter int ARENA_BYTES = ffha_pkg::ARENA_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ffha_pkg::REQ_TDATA_W-1:0]   req_tdata,  // size_bytes, payload_offset
   input  logic [ffha_pkg::OP_W-1:0]          req_tuser,  // operation
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ffha_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // granted_offset
   output logic                               rsp_tuser   // status
);

   `include "first_fit_heap_allocator_assert.svh"

   localparam int AW = $clog2(ARENA_BYTES);
   localparam int HW = $clog2(ARENA_BYTES + 1) + ffha_pkg::FLAG_NUM;

   logic                 res_valid;
   logic                 rsp_free;
   ffha_pkg::result_type res;
   logic                 rsp_valid_ff, rsp_valid_in;
   ffha_pkg::result_type rsp_ff, rsp_in;
   logic                 rd_en, wr_en;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic [HW-1:0]        rd_data, wr_data;

   ffha_ctrl #(.ARENA_BYTES(ARENA_BYTES)) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_tvalid),
      .req_ready          (req_tready),
      .req_operation      (req_tuser),
      .req_size_bytes     (req_tdata[ffha_pkg::SIZE_W-1:0]),
      .req_payload_offset (req_tdata[ffha_pkg::SIZE_W+ffha_pkg::OFFS_W-1:ffha_pkg::SIZE_W]),
      .res_valid          (res_valid),
      .res_ready          (rsp_free),
      .res                (res),
      .rd_en              (rd_en),
      .rd_addr            (rd_addr),
      .rd_data            (rd_data),
      .wr_en              (wr_en),
      .wr_addr            (wr_addr),
      .wr_data            (wr_data)
   );

   ffha_hdr_mem #(.ARENA_BYTES(ARENA_BYTES)) u_hdr_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_comb begin
      rsp_free     = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_tready);
      rsp_in       = (res_valid && rsp_free) ? res : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = ffha_pkg::RSP_TDATA_W'(rsp_ff.granted_offset);

   `FFHA_ASSERT(a_fail_zero_offset, clock, reset,
                rsp_tvalid && (rsp_tuser == ffha_pkg::STATUS_FAIL), rsp_tdata == '0)

endmodule
